FILE: hw/rtl/peq_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// peq_pkg: shared types and constants of the priority exclusion queue
// Result status codes, fixed port field widths and the per-cell command.
// ----------------------------------------------------------------------------
package peq_pkg;

    // Fixed widths of the port fields
    localparam int PRIO_IN_W = 8;
    localparam int DATA_IN_W = 32;
    localparam int OCC_W     = 5;

    // Command codes
    typedef enum logic {
        CMD_INSERT = 1'b0,
        CMD_REMOVE = 1'b1
    } cmd_t;

    // Result status codes
    typedef enum logic [1:0] {
        ST_INSERTED = 2'd0,
        ST_REMOVED  = 2'd1,
        ST_EMPTY    = 2'd2,
        ST_FULL     = 2'd3
    } status_t;

    // Command broadcast to every cell of the chain
    typedef struct packed {
        logic ins;   // store the new entry at its sorted place
        logic rem;   // drop the head, everything moves one cell down
    } peq_ctrl_t;

endpackage

FILE: hw/rtl/peq_cell.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// peq_cell: one slot of the sorted entry chain
// Holds one entry. Compares the incoming entry against its own priority and
// takes the new entry, its lower neighbor's entry or its upper neighbor's.
// ----------------------------------------------------------------------------
module peq_cell #(
    parameter int PRIO_WIDTH = 8,
    parameter int DATA_WIDTH = 32
) (
    input  logic                   aclk,
    input  peq_pkg::peq_ctrl_t     ctrl,
    input  logic                   own_valid,
    input  logic [PRIO_WIDTH-1:0]  new_prio,
    input  logic [DATA_WIDTH-1:0]  new_data,
    input  logic                   lo_ge,
    input  logic [PRIO_WIDTH-1:0]  lo_prio,
    input  logic [DATA_WIDTH-1:0]  lo_data,
    input  logic [PRIO_WIDTH-1:0]  hi_prio,
    input  logic [DATA_WIDTH-1:0]  hi_data,
    output logic [PRIO_WIDTH-1:0]  prio,
    output logic [DATA_WIDTH-1:0]  data,
    output logic                   ge
);
    import peq_pkg::*;

    logic [PRIO_WIDTH-1:0] prio_reg, prio_next;
    logic [DATA_WIDTH-1:0] data_reg, data_next;

    // New entry goes ahead of an equal priority: newest of a tie leaves first
    assign ge = !own_valid || (new_prio >= prio_reg);

    // Slot update
    always_comb begin
        prio_next = prio_reg;
        data_next = data_reg;
        if (ctrl.rem) begin
            prio_next = hi_prio;
            data_next = hi_data;
        end else if (ctrl.ins) begin
            if (lo_ge) begin
                prio_next = lo_prio;
                data_next = lo_data;
            end else if (ge) begin
                prio_next = new_prio;
                data_next = new_data;
            end
        end
    end

    always_ff @(posedge aclk) begin
        prio_reg <= prio_next;
        data_reg <= data_next;
    end

    assign prio = prio_reg;
    assign data = data_reg;

endmodule

FILE: hw/rtl/priority_exclusion_queue_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// priority_exclusion_queue_unit: bounded priority queue, remove-max
// Entries sit in a chain of cells sorted by priority, highest at cell 0,
// newest first among equal priorities. Insert places the entry by a compare
// in every cell; remove hands out cell 0 and shifts the chain down.
//
//   channel | direction | fields
//   s_      | in        | command, priority_req, payload
//   m_      | out       | status, out_priority, out_payload, occupancy
//
// One command is taken per cycle while s_ready is high; its result shows in
// the cycle after the transfer, with the chain's single compare-and-shift step.
// Reset empties the queue at once; the slots themselves are not cleared.
// A result waiting on m_ready holds s_ready low only when it is not taken.
// ----------------------------------------------------------------------------
module priority_exclusion_queue_unit #(
    parameter int DEPTH      = 16,
    parameter int PRIO_WIDTH = 8,
    parameter int DATA_WIDTH = 32
) (
    input  logic                                   aclk,
    input  logic                                   aresetn,
    input  logic                                   s_valid,
    output logic                                   s_ready,
    input  logic                                   s_command,
    input  logic [peq_pkg::PRIO_IN_W-1:0]          s_priority_req,
    input  logic signed [peq_pkg::DATA_IN_W-1:0]   s_payload,
    output logic                                   m_valid,
    input  logic                                   m_ready,
    output logic [1:0]                             m_status,
    output logic [peq_pkg::PRIO_IN_W-1:0]          m_out_priority,
    output logic signed [peq_pkg::DATA_IN_W-1:0]   m_out_payload,
    output logic [peq_pkg::OCC_W-1:0]              m_occupancy
);
    import peq_pkg::*;

    localparam int CNT_W = $clog2(DEPTH + 1);

    logic                  take;
    logic                  is_remove;
    logic                  full;
    logic                  empty;
    peq_ctrl_t             ctrl;
    logic [31:0]           prio_ext;
    logic [63:0]           data_ext;
    logic [PRIO_WIDTH-1:0] new_prio;
    logic [DATA_WIDTH-1:0] new_data;

    logic [CNT_W-1:0]      count_reg, count_next;
    logic                  m_valid_reg, m_valid_next;
    status_t               status_reg, status_next;
    logic [PRIO_IN_W-1:0]  oprio_reg, oprio_next;
    logic [DATA_IN_W-1:0]  odata_reg, odata_next;
    logic [OCC_W-1:0]      occ_reg, occ_next;

    logic [PRIO_WIDTH-1:0] cell_prio [DEPTH];
    logic [DATA_WIDTH-1:0] cell_data [DEPTH];
    logic                  cell_ge   [DEPTH];
    logic                  cell_vld  [DEPTH];

    logic [31:0]           head_prio_ext;
    logic [63:0]           head_data_ext;
    logic [31:0]           cnt_ext;

    // Handshake: a waiting result blocks only if it is not being taken
    assign s_ready   = !m_valid_reg || m_ready;
    assign take      = s_valid && s_ready;
    assign is_remove = (s_command == CMD_REMOVE);
    assign full      = (count_reg == CNT_W'(DEPTH));
    assign empty     = (count_reg == '0);

    // Command to the chain
    assign ctrl.ins = take && !is_remove && !full;
    assign ctrl.rem = take && is_remove && !empty;

    // Field width adaptation
    assign prio_ext = 32'(s_priority_req);
    assign data_ext = 64'($unsigned(s_payload));
    assign new_prio = prio_ext[PRIO_WIDTH-1:0];
    assign new_data = data_ext[DATA_WIDTH-1:0];

    // Cell chain
    for (genvar i = 0; i < DEPTH; i++) begin : g_cell
        logic                  lo_ge;
        logic [PRIO_WIDTH-1:0] lo_prio;
        logic [DATA_WIDTH-1:0] lo_data;
        logic [PRIO_WIDTH-1:0] hi_prio;
        logic [DATA_WIDTH-1:0] hi_data;

        assign cell_vld[i] = (CNT_W'(i) < count_reg);

        if (i == 0) begin : g_first
            assign lo_ge   = 1'b0;
            assign lo_prio = '0;
            assign lo_data = '0;
        end else begin : g_mid
            assign lo_ge   = cell_ge[i-1];
            assign lo_prio = cell_prio[i-1];
            assign lo_data = cell_data[i-1];
        end

        if (i == DEPTH - 1) begin : g_last
            assign hi_prio = '0;
            assign hi_data = '0;
        end else begin : g_below
            assign hi_prio = cell_prio[i+1];
            assign hi_data = cell_data[i+1];
        end

        peq_cell #(
            .PRIO_WIDTH (PRIO_WIDTH),
            .DATA_WIDTH (DATA_WIDTH)
        ) u_cell (
            .aclk      (aclk),
            .ctrl      (ctrl),
            .own_valid (cell_vld[i]),
            .new_prio  (new_prio),
            .new_data  (new_data),
            .lo_ge     (lo_ge),
            .lo_prio   (lo_prio),
            .lo_data   (lo_data),
            .hi_prio   (hi_prio),
            .hi_data   (hi_data),
            .prio      (cell_prio[i]),
            .data      (cell_data[i]),
            .ge        (cell_ge[i])
        );
    end

    // Head of the chain, fitted to the result fields
    assign head_prio_ext = 32'(cell_prio[0]);
    assign head_data_ext = 64'(cell_data[0]);

    // Count and result register
    always_comb begin
        count_next   = count_reg;
        m_valid_next = m_valid_reg;
        status_next  = status_reg;
        oprio_next   = oprio_reg;
        odata_next   = odata_reg;
        if (m_valid_reg && m_ready) begin
            m_valid_next = 1'b0;
        end
        if (take) begin
            m_valid_next = 1'b1;
            oprio_next   = '0;
            odata_next   = '0;
            if (ctrl.ins) begin
                count_next  = count_reg + CNT_W'(1);
                status_next = ST_INSERTED;
            end else if (ctrl.rem) begin
                count_next  = count_reg - CNT_W'(1);
                status_next = ST_REMOVED;
                oprio_next  = head_prio_ext[PRIO_IN_W-1:0];
                odata_next  = head_data_ext[DATA_IN_W-1:0];
            end else if (is_remove) begin
                status_next = ST_EMPTY;
            end else begin
                status_next = ST_FULL;
            end
        end
    end

    assign cnt_ext  = 32'(count_next);
    assign occ_next = take ? cnt_ext[OCC_W-1:0] : occ_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg   <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            count_reg   <= count_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        status_reg <= status_next;
        oprio_reg  <= oprio_next;
        odata_reg  <= odata_next;
        occ_reg    <= occ_next;
    end

    assign m_valid        = m_valid_reg;
    assign m_status       = status_reg;
    assign m_out_priority = oprio_reg;
    assign m_out_payload  = odata_reg;
    assign m_occupancy    = occ_reg;

endmodule

FILE: bench/priority_exclusion_queue_unit_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// priority_exclusion_queue_unit_test: self-checking bench for the remove-max queue
// Drives insert and remove commands on s_ with random gaps and checks every m_
// transfer against a shadow copy of the queue. The shadow copy keeps entries in
// arrival order and removes the highest priority, newest first on a tie.
// Directed commands cover empty, full, ties and field extremes. Random phases
// lean toward filling, draining or neither, so that both ends are reached often.
// ----------------------------------------------------------------------------
module priority_exclusion_queue_unit_test;
    import peq_pkg::*;

    localparam int QDEPTH      = 16;
    localparam int CYCLE_LIMIT = 400000;

    typedef struct {
        cmd_t                  cmd;
        logic [PRIO_IN_W-1:0]  prio;
        logic [DATA_IN_W-1:0]  data;
    } command_t;

    typedef struct {
        logic [PRIO_IN_W-1:0]  prio;
        logic [DATA_IN_W-1:0]  data;
    } entry_t;

    typedef struct {
        status_t               status;
        logic [PRIO_IN_W-1:0]  prio;
        logic [DATA_IN_W-1:0]  data;
        logic [OCC_W-1:0]      occ;
    } outcome_t;

    // Clock, reset and DUT ports
    logic                        aclk           = 1'b0;
    logic                        aresetn        = 1'b0;
    logic                        s_valid        = 1'b0;
    logic                        s_ready;
    logic                        s_command      = CMD_INSERT;
    logic [PRIO_IN_W-1:0]        s_priority_req = '0;
    logic signed [DATA_IN_W-1:0] s_payload      = '0;
    logic                        m_valid;
    logic                        m_ready        = 1'b0;
    logic [1:0]                  m_status;
    logic [PRIO_IN_W-1:0]        m_out_priority;
    logic signed [DATA_IN_W-1:0] m_out_payload;
    logic [OCC_W-1:0]            m_occupancy;

    // Bench state
    command_t  cmd_backlog[$];
    entry_t    shadow_entries[$];
    outcome_t  awaited_results[$];
    command_t  next_cmd;
    outcome_t  want;
    logic      s_taken      = 1'b0;
    int        tx_gap       = 0;
    bit        tx_steady    = 1'b0;
    int        rx_gap       = 0;
    int        rx_hold      = 0;
    bit        rx_steady    = 1'b0;
    int        results_seen = 0;
    int        next_hold_at = 150;
    int        errors       = 0;
    int        cycles       = 0;

    priority_exclusion_queue_unit #(
        .DEPTH      (QDEPTH),
        .PRIO_WIDTH (8),
        .DATA_WIDTH (32)
    ) u_top (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_command      (s_command),
        .s_priority_req (s_priority_req),
        .s_payload      (s_payload),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_status       (m_status),
        .m_out_priority (m_out_priority),
        .m_out_payload  (m_out_payload),
        .m_occupancy    (m_occupancy)
    );

    always begin
        #2 aclk = 1'b1;
        #2 aclk = 1'b0;
    end

    // Apply one command to the shadow queue and return the result it gives
    function automatic outcome_t apply_command(command_t c);
        outcome_t r;
        int       best;
        r.prio = '0;
        r.data = '0;
        if (c.cmd == CMD_INSERT) begin
            if (shadow_entries.size() >= QDEPTH) begin
                r.status = ST_FULL;
            end else begin
                shadow_entries.push_back('{prio: c.prio, data: c.data});
                r.status = ST_INSERTED;
            end
        end else if (shadow_entries.size() == 0) begin
            r.status = ST_EMPTY;
        end else begin
            // downward scan: a strictly higher priority below replaces the pick
            best = shadow_entries.size() - 1;
            for (int i = shadow_entries.size() - 2; i >= 0; i--) begin
                if (shadow_entries[i].prio > shadow_entries[best].prio)
                    best = i;
            end
            r.prio = shadow_entries[best].prio;
            r.data = shadow_entries[best].data;
            shadow_entries.delete(best);
            r.status = ST_REMOVED;
        end
        r.occ = OCC_W'(shadow_entries.size());
        return r;
    endfunction

    // Random command; ins_pct sets the share of inserts
    function automatic command_t make_command(int ins_pct);
        command_t c;
        int       pick;
        c.cmd  = ($urandom_range(0, 99) < ins_pct) ? CMD_INSERT : CMD_REMOVE;
        c.data = $urandom;
        pick   = $urandom_range(0, 99);
        if (pick < 40)
            c.prio = PRIO_IN_W'($urandom_range(0, 3));      // crowd of ties
        else if (pick < 50)
            c.prio = $urandom_range(0, 1) ? 8'hFF : 8'h00;
        else
            c.prio = PRIO_IN_W'($urandom_range(0, 255));
        return c;
    endfunction

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 70)
            return 0;
        else if (r < 93)
            return $urandom_range(1, 3);
        else
            return $urandom_range(6, 40);
    endfunction

    task automatic queue_insert(logic [PRIO_IN_W-1:0] p, logic [DATA_IN_W-1:0] d);
        cmd_backlog.push_back('{cmd: CMD_INSERT, prio: p, data: d});
    endtask

    task automatic queue_remove();
        cmd_backlog.push_back('{cmd: CMD_REMOVE, prio: PRIO_IN_W'($urandom),
                                data: $urandom});
    endtask

    // Wait until the backlog is sent and every result has come back
    task automatic drain();
        do begin
            @(posedge aclk);
        end while (cmd_backlog.size() != 0 || s_valid || awaited_results.size() != 0);
        @(posedge aclk);
    endtask

    task automatic cmp_field(string what, logic [31:0] exp_v, logic [31:0] got_v);
        if (exp_v !== got_v) begin
            errors++;
            $display("%0t ns: %s mismatch, expected 0x%0h, actual 0x%0h",
                     $time, what, exp_v, got_v);
        end
    endtask

    // Input driver: next command from the backlog, random gaps between transfers
    always @(negedge aclk) begin
        if (!aresetn) begin
            s_valid <= 1'b0;
        end else if (s_valid && !s_taken) begin
            // hold the offered command until the transfer
        end else if (tx_gap > 0) begin
            s_valid <= 1'b0;
            tx_gap  <= tx_gap - 1;
        end else if (cmd_backlog.size() > 0) begin
            next_cmd       = cmd_backlog.pop_front();
            s_valid        <= 1'b1;
            s_command      <= next_cmd.cmd;
            s_priority_req <= next_cmd.prio;
            s_payload      <= next_cmd.data;
            tx_gap         <= tx_steady ? 0 : pick_gap();
            if ($urandom_range(0, 99) < 3)
                tx_steady <= !tx_steady;
        end else begin
            s_valid <= 1'b0;
        end
    end

    // Result receiver: random stalls plus long hold-offs to back up the input
    always @(negedge aclk) begin
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else if (rx_hold > 0) begin
            m_ready <= 1'b0;
            rx_hold <= rx_hold - 1;
        end else if (results_seen >= next_hold_at) begin
            m_ready      <= 1'b0;
            rx_hold      <= 250;
            next_hold_at <= next_hold_at + 300;
        end else if (rx_gap > 0) begin
            m_ready <= 1'b0;
            rx_gap  <= rx_gap - 1;
        end else begin
            m_ready <= 1'b1;
            if (!rx_steady)
                rx_gap <= pick_gap();
            if ($urandom_range(0, 99) < 2)
                rx_steady <= !rx_steady;
        end
    end

    // Monitor: check m_ transfers, then predict from s_ transfers
    always @(posedge aclk) begin
        if (aresetn) begin
            if (m_valid && m_ready) begin
                results_seen <= results_seen + 1;
                if (awaited_results.size() == 0) begin
                    errors++;
                    $display("%0t ns: unexpected result, expected none, actual status %0d",
                             $time, m_status);
                end else begin
                    want = awaited_results.pop_front();
                    cmp_field("status", 32'(want.status), 32'(m_status));
                    cmp_field("out_priority", 32'(want.prio), 32'(m_out_priority));
                    cmp_field("out_payload", want.data, m_out_payload);
                    cmp_field("occupancy", 32'(want.occ), 32'(m_occupancy));
                end
            end
            if (s_valid && s_ready) begin
                awaited_results.push_back(apply_command('{cmd: cmd_t'(s_command),
                                                          prio: s_priority_req,
                                                          data: s_payload}));
            end
        end
        s_taken <= aresetn && s_valid && s_ready;
    end

    // Watchdog
    always @(posedge aclk) begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT) begin
            $display("Verification failed");
            $finish;
        end
    end

    // Stimulus and end of run
    initial begin
        repeat (2) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        // Directed: empty remove, ties, extremes, fill to full
        queue_remove();
        queue_insert(8'h00, 32'h0000_0000);
        queue_insert(8'hFF, 32'h7FFF_FFFF);
        queue_insert(8'hFF, 32'h8000_0000);     // tie: newest leaves first
        queue_insert(8'h00, 32'hFFFF_FFFF);
        repeat (3) queue_remove();
        for (int i = 0; i < QDEPTH - 1; i++)
            queue_insert(8'(i % 4), $urandom);
        queue_insert(8'hAA, 32'h5555_5555);     // full: dropped
        queue_remove();
        drain();

        // Random phases: fill-heavy, drain-heavy, then balanced
        for (int ph = 0; ph < 4; ph++) begin
            for (int n = 0; n < 180; n++)
                cmd_backlog.push_back(make_command(ph == 0 ? 75 : ph == 1 ? 30 : 52));
            drain();
        end

        repeat (8) @(posedge aclk);
        if (errors == 0 && awaited_results.size() == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule

FILE: priority_exclusion_queue_unit.f
hw/rtl/peq_pkg.sv
hw/rtl/peq_cell.sv
hw/rtl/priority_exclusion_queue_unit.sv
bench/priority_exclusion_queue_unit_test.sv
